[sv/client_source_binding_table_unit_defines.svh]
// Assertion macros for the client/source binding table.
// Expects clk and rst_n in the scope of each use.
`ifndef CLIENT_SOURCE_BINDING_TABLE_UNIT_DEFINES_SVH
`define CLIENT_SOURCE_BINDING_TABLE_UNIT_DEFINES_SVH

// same-cycle implication
`define CSBT_CHECK(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csbt check failed");

// next-cycle implication
`define CSBT_CHECK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csbt check failed");

`endif

[sv/csbt_pkg.sv]
// Shared widths, command codes, write-control structs and the index width helper.
// No dependencies.
package csbt_pkg;

  localparam int ID_W   = 32;
  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int SRC_W  = ADDR_W + PORT_W;

  typedef enum logic [1:0] {
    CMD_CREATE        = 2'd0,
    CMD_DELETE        = 2'd1,
    CMD_LOOKUP_CLIENT = 2'd2,
    CMD_LOOKUP_SOURCE = 2'd3
  } csbt_cmd_t;

  typedef enum logic {
    ST_OK   = 1'b0,
    ST_FULL = 1'b1
  } csbt_status_t;

  // client table write controls
  typedef struct packed {
    logic set_vld;
    logic clr_vld;
    logic wr_src;
  } csbt_cwr_t;

  // source table write controls
  typedef struct packed {
    logic clr;
    logic wr_client;
    logic set_key;
  } csbt_swr_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[sv/csbt_client_tab.sv]
// Client table: client keys with bound 48-bit sources, parallel key match.
// Depends on csbt_pkg.
module csbt_client_tab import csbt_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [ID_W-1:0]           lk_key,
  output logic                      lk_hit,
  output logic [idx_w(ENTRIES)-1:0] lk_idx,
  output logic [SRC_W-1:0]          lk_src,
  output logic                      fr_hit,
  output logic [idx_w(ENTRIES)-1:0] fr_idx,
  input  csbt_cwr_t                 wr,
  input  logic [idx_w(ENTRIES)-1:0] wr_idx,
  input  logic [ID_W-1:0]           wr_key,
  input  logic [SRC_W-1:0]          wr_src
);

  localparam int IW = idx_w(ENTRIES);

  logic [ENTRIES-1:0] vld_r, vld_nxt;
  logic [ID_W-1:0]    keys_r [ENTRIES];
  logic [SRC_W-1:0]   src_r  [ENTRIES];
  logic [ENTRIES-1:0] match;

  always_comb begin
    lk_hit = 1'b0;
    lk_idx = '0;
    fr_hit = 1'b0;
    fr_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      match[i] = vld_r[i] && (keys_r[i] == lk_key);
      if (match[i]) begin
        lk_hit = 1'b1;
        lk_idx = IW'(i);
      end
      if (!vld_r[i]) begin
        fr_hit = 1'b1;
        fr_idx = IW'(i);
      end
    end
  end

  assign lk_src = src_r[lk_idx];

  always_comb begin
    vld_nxt = vld_r;
    if (wr.clr_vld) begin
      vld_nxt[wr_idx] = 1'b0;
    end
    if (wr.set_vld) begin
      vld_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set_vld) begin
      keys_r[wr_idx] <= wr_key;
    end
    if (wr.set_vld || wr.wr_src) begin
      src_r[wr_idx] <= wr_src;
    end
  end

endmodule

[sv/csbt_source_tab.sv]
// Source table: 48-bit source keys with bound client keys, parallel key match.
// Depends on csbt_pkg; erase-aware match and free search for the create path.
module csbt_source_tab import csbt_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [SRC_W-1:0]          key_new,
  output logic                      raw_hit,
  output logic [idx_w(ENTRIES)-1:0] raw_idx,
  output logic [ID_W-1:0]           raw_client,
  input  logic [SRC_W-1:0]          key_old,
  input  logic                      erase_en,
  output logic                      old_hit,
  output logic [idx_w(ENTRIES)-1:0] old_idx,
  output logic                      new_hit,
  output logic [idx_w(ENTRIES)-1:0] new_idx,
  output logic                      fr_hit,
  output logic [idx_w(ENTRIES)-1:0] fr_idx,
  input  csbt_swr_t                 wr,
  input  logic [idx_w(ENTRIES)-1:0] clr_idx,
  input  logic [idx_w(ENTRIES)-1:0] wr_idx,
  input  logic [SRC_W-1:0]          wr_key,
  input  logic [ID_W-1:0]           wr_client
);

  localparam int IW = idx_w(ENTRIES);

  logic [ENTRIES-1:0] vld_r, vld_nxt;
  logic [SRC_W-1:0]   keys_r    [ENTRIES];
  logic [ID_W-1:0]    clients_r [ENTRIES];
  logic [ENTRIES-1:0] m_new, m_old, gone;

  always_comb begin
    raw_hit = 1'b0;
    raw_idx = '0;
    old_hit = 1'b0;
    old_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      m_new[i] = vld_r[i] && (keys_r[i] == key_new);
      m_old[i] = vld_r[i] && (keys_r[i] == key_old);
      if (m_new[i]) begin
        raw_hit = 1'b1;
        raw_idx = IW'(i);
      end
      if (m_old[i]) begin
        old_hit = 1'b1;
        old_idx = IW'(i);
      end
    end
  end

  assign raw_client = clients_r[raw_idx];

  // match and free search as seen after the old source is erased
  always_comb begin
    new_hit = 1'b0;
    new_idx = '0;
    fr_hit  = 1'b0;
    fr_idx  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      gone[i] = erase_en && old_hit && (old_idx == IW'(i));
      if (m_new[i] && !gone[i]) begin
        new_hit = 1'b1;
        new_idx = IW'(i);
      end
      if (!vld_r[i] || gone[i]) begin
        fr_hit = 1'b1;
        fr_idx = IW'(i);
      end
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (wr.clr) begin
      vld_nxt[clr_idx] = 1'b0;
    end
    if (wr.set_key) begin
      vld_nxt[wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set_key) begin
      keys_r[wr_idx] <= wr_key;
    end
    if (wr.set_key || wr.wr_client) begin
      clients_r[wr_idx] <= wr_client;
    end
  end

endmodule

[sv/client_source_binding_table_unit.sv]
// Each word is held in the input register and sees the tables as left by the one before;
// its result goes to the result register. One word per cycle while out_ready does not stall.
// Table work is one pass of parallel key match over both tables between the two registers.
// Reset (rst_n, synchronous, active low) clears all valid bits and both channel stages.
// Top level; depends on csbt_pkg, csbt_client_tab, csbt_source_tab and the defines header.
`include "client_source_binding_table_unit_defines.svh"

module client_source_binding_table_unit import csbt_pkg::*; #(
  parameter int CLIENT_ENTRIES = 16,
  parameter int SOURCE_ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [ID_W-1:0]   in_client_key,
  input  logic [ADDR_W-1:0] in_source_addr,
  input  logic [PORT_W-1:0] in_source_port,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [ID_W-1:0]   out_found_client,
  output logic [ADDR_W-1:0] out_found_addr,
  output logic [PORT_W-1:0] out_found_port,
  output logic              out_status
);

  localparam int CIW = idx_w(CLIENT_ENTRIES);
  localparam int SIW = idx_w(SOURCE_ENTRIES);

  logic              in_vld_r;
  csbt_cmd_t         cmd_r;
  logic [ID_W-1:0]   id_r;
  logic [ADDR_W-1:0] addr_r;
  logic [PORT_W-1:0] port_r;

  logic              out_vld_r;
  logic              found_r, found_nxt;
  logic [ID_W-1:0]   fclient_r, fclient_nxt;
  logic [ADDR_W-1:0] faddr_r, faddr_nxt;
  logic [PORT_W-1:0] fport_r, fport_nxt;
  csbt_status_t      status_r, status_nxt;

  logic              advance;
  logic [SRC_W-1:0]  src;

  logic              c_hit, cf_hit;
  logic [CIW-1:0]    c_idx, cf_idx, cw_idx;
  logic [SRC_W-1:0]  c_src;
  logic [ID_W-1:0]   c_key;
  csbt_cwr_t         cwr;

  logic              b_hit, a_hit, n_hit, sf_hit, erase_en;
  logic [SIW-1:0]    b_idx, a_idx, n_idx, sf_idx, sclr_idx, sw_idx;
  logic [ID_W-1:0]   b_client;
  csbt_swr_t         swr;

  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;
  assign src      = {addr_r, port_r};
  assign c_key    = (cmd_r == CMD_DELETE) ? b_client : id_r;
  assign erase_en = (cmd_r == CMD_CREATE) && c_hit;

  csbt_client_tab #(.ENTRIES(CLIENT_ENTRIES)) u_client (
    .clk    (clk),
    .rst_n  (rst_n),
    .lk_key (c_key),
    .lk_hit (c_hit),
    .lk_idx (c_idx),
    .lk_src (c_src),
    .fr_hit (cf_hit),
    .fr_idx (cf_idx),
    .wr     (cwr),
    .wr_idx (cw_idx),
    .wr_key (id_r),
    .wr_src (src)
  );

  csbt_source_tab #(.ENTRIES(SOURCE_ENTRIES)) u_source (
    .clk        (clk),
    .rst_n      (rst_n),
    .key_new    (src),
    .raw_hit    (b_hit),
    .raw_idx    (b_idx),
    .raw_client (b_client),
    .key_old    (c_src),
    .erase_en   (erase_en),
    .old_hit    (a_hit),
    .old_idx    (a_idx),
    .new_hit    (n_hit),
    .new_idx    (n_idx),
    .fr_hit     (sf_hit),
    .fr_idx     (sf_idx),
    .wr         (swr),
    .clr_idx    (sclr_idx),
    .wr_idx     (sw_idx),
    .wr_key     (src),
    .wr_client  (id_r)
  );

  always_comb begin
    cwr         = '0;
    cw_idx      = c_idx;
    swr         = '0;
    sclr_idx    = b_idx;
    sw_idx      = n_idx;
    found_nxt   = 1'b0;
    fclient_nxt = '0;
    faddr_nxt   = '0;
    fport_nxt   = '0;
    status_nxt  = ST_OK;
    case (cmd_r)
      CMD_CREATE: begin
        if (c_hit) begin
          cwr.wr_src = 1'b1;
          swr.clr    = a_hit;
          sclr_idx   = a_idx;
        end else if (cf_hit) begin
          cwr.set_vld = 1'b1;
          cw_idx      = cf_idx;
        end else begin
          status_nxt = ST_FULL;
        end
        if (n_hit) begin
          swr.wr_client = 1'b1;
        end else if (sf_hit) begin
          swr.set_key = 1'b1;
          sw_idx      = sf_idx;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      CMD_DELETE: begin
        if (b_hit) begin
          swr.clr     = 1'b1;
          cwr.clr_vld = c_hit;
          found_nxt   = 1'b1;
          fclient_nxt = b_client;
        end
      end
      CMD_LOOKUP_CLIENT: begin
        if (b_hit) begin
          found_nxt   = 1'b1;
          fclient_nxt = b_client;
        end
      end
      CMD_LOOKUP_SOURCE: begin
        if (c_hit) begin
          found_nxt = 1'b1;
          faddr_nxt = c_src[SRC_W-1:PORT_W];
          fport_nxt = c_src[PORT_W-1:0];
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
    if (!advance) begin
      cwr = '0;
      swr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= csbt_cmd_t'(in_cmd);
      id_r   <= in_client_key;
      addr_r <= in_source_addr;
      port_r <= in_source_port;
    end
    if (advance) begin
      found_r   <= found_nxt;
      fclient_r <= fclient_nxt;
      faddr_r   <= faddr_nxt;
      fport_r   <= fport_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_found        = found_r;
  assign out_found_client = fclient_r;
  assign out_found_addr   = faddr_r;
  assign out_found_port   = fport_r;
  assign out_status       = status_r;

  `CSBT_CHECK_NEXT(a_adv_fills_out, advance, out_vld_r)
  `CSBT_CHECK_NEXT(a_stall_holds_in, in_vld_r && !advance, in_vld_r && $stable(cmd_r))
  `CSBT_CHECK_NEXT(a_full_only_create, advance && cmd_r != CMD_CREATE, status_r == ST_OK)
  `CSBT_CHECK_NEXT(a_create_no_found, advance && cmd_r == CMD_CREATE, !found_r)
  `CSBT_CHECK(a_miss_zero, out_vld_r && !found_r, fclient_r == '0 && faddr_r == '0 && fport_r == '0)

endmodule

[tb/sv/tb_client_source_binding_table_unit.sv]
// Testbench for client_source_binding_table_unit: directed and random binding commands,
// each result word checked field by field against a behavioral copy of both tables.
// Depends on csbt_pkg and the unit RTL.
module tb_client_source_binding_table_unit;
  import csbt_pkg::*;

  localparam int CLIENT_ENTRIES = 16;
  localparam int SOURCE_ENTRIES = 16;
  localparam int RANDOM_WORDS   = 1425;
  localparam int POOL_SIZE      = 24;

  typedef struct {
    csbt_cmd_t         cmd;
    logic [ID_W-1:0]   client_key;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    int                phase;
    bit                drain;
  } binding_cmd_t;

  typedef struct {
    logic              found;
    logic [ID_W-1:0]   client;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    csbt_status_t      status;
  } binding_rsp_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_cmd = 2'b00;
  logic [ID_W-1:0]   in_client_key = '0;
  logic [ADDR_W-1:0] in_source_addr = '0;
  logic [PORT_W-1:0] in_source_port = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_found;
  logic [ID_W-1:0]   out_found_client;
  logic [ADDR_W-1:0] out_found_addr;
  logic [PORT_W-1:0] out_found_port;
  logic              out_status;

  binding_cmd_t cmd_words_q[$];
  binding_rsp_t binding_rsp_q[$];
  binding_cmd_t cur_cmd;
  int           live_phase = 0;
  int           mismatches = 0;

  bit                cl_used[CLIENT_ENTRIES];
  logic [ID_W-1:0]   cl_key[CLIENT_ENTRIES];
  logic [SRC_W-1:0]  cl_src[CLIENT_ENTRIES];
  bit                src_used[SOURCE_ENTRIES];
  logic [SRC_W-1:0]  src_key[SOURCE_ENTRIES];
  logic [ID_W-1:0]   src_client[SOURCE_ENTRIES];

  logic [ID_W-1:0]   client_pool[POOL_SIZE];
  logic [SRC_W-1:0]  source_pool[POOL_SIZE];

  client_source_binding_table_unit #(
    .CLIENT_ENTRIES(CLIENT_ENTRIES),
    .SOURCE_ENTRIES(SOURCE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_cmd(in_cmd),
    .in_client_key(in_client_key),
    .in_source_addr(in_source_addr),
    .in_source_port(in_source_port),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_found(out_found),
    .out_found_client(out_found_client),
    .out_found_addr(out_found_addr),
    .out_found_port(out_found_port),
    .out_status(out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int client_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < CLIENT_ENTRIES; i++)
      if (cl_used[i] && cl_key[i] == id) return i;
    return -1;
  endfunction

  function automatic int source_slot(logic [SRC_W-1:0] key);
    for (int i = 0; i < SOURCE_ENTRIES; i++)
      if (src_used[i] && src_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int free_client_slot();
    for (int i = 0; i < CLIENT_ENTRIES; i++)
      if (!cl_used[i]) return i;
    return -1;
  endfunction

  function automatic int free_source_slot();
    for (int i = 0; i < SOURCE_ENTRIES; i++)
      if (!src_used[i]) return i;
    return -1;
  endfunction

  function automatic binding_rsp_t apply_binding_cmd(binding_cmd_t w);
    binding_rsp_t     r;
    logic [SRC_W-1:0] key;
    logic [ID_W-1:0]  bound;
    int               c;
    int               s;
    r = '{found: 1'b0, client: '0, addr: '0, port: '0, status: ST_OK};
    key = {w.addr, w.port};
    case (w.cmd)
      CMD_CREATE: begin
        c = client_slot(w.client_key);
        if (c >= 0) begin
          s = source_slot(cl_src[c]);
          if (s >= 0) src_used[s] = 1'b0;
          cl_src[c] = key;
        end else begin
          c = free_client_slot();
          if (c >= 0) begin
            cl_used[c] = 1'b1;
            cl_key[c] = w.client_key;
            cl_src[c] = key;
          end else begin
            r.status = ST_FULL;
          end
        end
        s = source_slot(key);
        if (s >= 0) begin
          src_client[s] = w.client_key;
        end else begin
          s = free_source_slot();
          if (s >= 0) begin
            src_used[s] = 1'b1;
            src_key[s] = key;
            src_client[s] = w.client_key;
          end else begin
            r.status = ST_FULL;
          end
        end
      end
      CMD_DELETE: begin
        s = source_slot(key);
        if (s >= 0) begin
          bound = src_client[s];
          c = client_slot(bound);
          if (c >= 0) cl_used[c] = 1'b0;
          src_used[s] = 1'b0;
          r.found = 1'b1;
          r.client = bound;
        end
      end
      CMD_LOOKUP_CLIENT: begin
        s = source_slot(key);
        if (s >= 0) begin
          r.found = 1'b1;
          r.client = src_client[s];
        end
      end
      default: begin
        c = client_slot(w.client_key);
        if (c >= 0) begin
          r.found = 1'b1;
          r.addr = cl_src[c][SRC_W-1:PORT_W];
          r.port = cl_src[c][PORT_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

  function automatic int tx_idle_pct(int phase);
    return (phase == 0) ? 25 : (phase == 1) ? 65 : 0;
  endfunction

  function automatic int rx_idle_pct(int phase);
    return (phase == 0) ? 65 : (phase == 1) ? 25 : 0;
  endfunction

  task automatic queue_word(csbt_cmd_t cmd, logic [ID_W-1:0] id, logic [ADDR_W-1:0] addr,
                            logic [PORT_W-1:0] port, int phase, bit drain);
    binding_cmd_t w;
    w = '{cmd: cmd, client_key: id, addr: addr, port: port, phase: phase, drain: drain};
    cmd_words_q.push_back(w);
  endtask

  always @(posedge clk) begin : drive
    binding_cmd_t nxt;
    logic         busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        binding_rsp_q.push_back(apply_binding_cmd(cur_cmd));
        busy = 1'b0;
      end
      if (!busy && cmd_words_q.size() != 0) begin
        nxt = cmd_words_q[0];
        if (!(nxt.drain && binding_rsp_q.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct(nxt.phase)) begin
          cur_cmd = cmd_words_q.pop_front();
          in_cmd <= cur_cmd.cmd;
          in_client_key <= cur_cmd.client_key;
          in_source_addr <= cur_cmd.addr;
          in_source_port <= cur_cmd.port;
          live_phase <= cur_cmd.phase;
          busy = 1'b1;
        end
      end
      in_valid <= busy;
    end
  end

  always @(posedge clk) begin : observe
    binding_rsp_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (binding_rsp_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: found=%0b client=%h addr=%h port=%h status=%0b",
                     out_found, out_found_client, out_found_addr, out_found_port, out_status);
        end else begin
          want = binding_rsp_q.pop_front();
          if (out_found !== want.found || out_found_client !== want.client ||
              out_found_addr !== want.addr || out_found_port !== want.port ||
              out_status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0b %h %h %h %0b, got %0b %h %h %h %0b",
                       want.found, want.client, want.addr, want.port, want.status,
                       out_found, out_found_client, out_found_addr, out_found_port,
                       out_status);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct(live_phase));
    end
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int               ph;
    int               prev_ph;
    int               span;
    int               r;
    csbt_cmd_t        c;
    logic [ID_W-1:0]  id;
    logic [SRC_W-1:0] key;

    client_pool[0] = '0;
    client_pool[1] = '1;
    source_pool[0] = '0;
    source_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) begin
      client_pool[i] = $urandom;
      source_pool[i] = {$urandom, 16'($urandom)};
    end

    queue_word(CMD_LOOKUP_CLIENT, '0, '0, '0, 0, 1'b0);
    queue_word(CMD_LOOKUP_SOURCE, '1, '1, '1, 0, 1'b0);
    queue_word(CMD_DELETE, '0, '1, '0, 0, 1'b0);
    queue_word(CMD_CREATE, '0, '1, '1, 0, 1'b0);
    queue_word(CMD_CREATE, '1, '0, '0, 0, 1'b0);
    queue_word(CMD_LOOKUP_SOURCE, '0, '0, '0, 0, 1'b0);
    queue_word(CMD_LOOKUP_CLIENT, '0, '0, '0, 0, 1'b0);
    queue_word(CMD_CREATE, '0, 32'h0a00_0001, 16'd80, 0, 1'b0);
    queue_word(CMD_LOOKUP_CLIENT, '0, '1, '1, 0, 1'b0);
    queue_word(CMD_CREATE, 32'h0000_00a5, '0, '0, 0, 1'b0);
    queue_word(CMD_LOOKUP_SOURCE, '1, '0, '0, 0, 1'b0);
    queue_word(CMD_DELETE, '0, '0, '0, 0, 1'b0);
    queue_word(CMD_LOOKUP_SOURCE, 32'h0000_00a5, '0, '0, 0, 1'b0);
    // fill both tables, then overflow the client table
    for (int i = 0; i < 15; i++)
      queue_word(CMD_CREATE, 32'h100 + i, 32'hc0a8_0000 + i, 16'(1000 + i), 0, 1'b0);
    queue_word(CMD_CREATE, '0, 32'h0a00_0002, 16'd81, 0, 1'b0);
    queue_word(CMD_CREATE, 32'h200, 32'h0a00_0003, 16'd82, 0, 1'b0);

    prev_ph = -1;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      ph = n * 3 / RANDOM_WORDS;
      span = (ph == 1) ? POOL_SIZE : 12;
      r = $urandom_range(99);
      c = (r < 40) ? CMD_CREATE : (r < 60) ? CMD_DELETE :
          (r < 80) ? CMD_LOOKUP_CLIENT : CMD_LOOKUP_SOURCE;
      id = ($urandom_range(99) < 85) ? client_pool[$urandom_range(span - 1)] : $urandom;
      key = ($urandom_range(99) < 85) ? source_pool[$urandom_range(span - 1)]
                                      : {$urandom, 16'($urandom)};
      queue_word(c, id, key[SRC_W-1:PORT_W], key[PORT_W-1:0], ph, ph != prev_ph);
      prev_ph = ph;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_words_q.size() != 0 || in_valid || binding_rsp_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[client_source_binding_table_unit.f]
+incdir+sv
sv/csbt_pkg.sv
sv/csbt_client_tab.sv
sv/csbt_source_tab.sv
sv/client_source_binding_table_unit.sv
tb/sv/tb_client_source_binding_table_unit.sv
